>>> src/cdd_pkg.sv
package cdd_pkg;

    // Timestamps wrap at the width of the now_ms field
    localparam int unsigned TIME_BITS  = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 2'd2;

    localparam logic [15:0] RESET_POLL_MS     = 16'd10;
    localparam logic [15:0] RESET_DEBOUNCE_MS = 16'd50;
    localparam logic        RESET_ACTIVE_LOW  = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 pin_level;
        logic                 take_inserted;
        logic                 resync;
    } t_in;

    typedef struct packed {
        logic changed;
        logic inserted_taken;
        logic removed_pending_out;
        logic inserted_pending_out;
        logic card_present;
    } t_out;

    typedef struct packed {
        logic [15:0] poll_interval_ms;
        logic [15:0] debounce_ms;
        logic        active_low;
    } t_cfg;

endpackage

>>> src/cdd_cfg.sv
module cdd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cdd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cdd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cdd_pkg::t_cfg                    o_cfg
);

    cdd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_ms <= cdd_pkg::RESET_POLL_MS;
            r_cfg.debounce_ms      <= cdd_pkg::RESET_DEBOUNCE_MS;
            r_cfg.active_low       <= cdd_pkg::RESET_ACTIVE_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdd_pkg::REG_POLL_INTERVAL: r_cfg.poll_interval_ms <= i_cfg_data;
                cdd_pkg::REG_DEBOUNCE:      r_cfg.debounce_ms      <= i_cfg_data;
                cdd_pkg::REG_ACTIVE_LOW:    r_cfg.active_low       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/cdd_core.sv
module cdd_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdd_pkg::t_in  i_item,
    input  cdd_pkg::t_cfg i_cfg,
    input  logic          i_commit,
    output cdd_pkg::t_out o_result
);

    localparam int unsigned TW = cdd_pkg::TIME_BITS;

    logic          r_known,    n_known;
    logic          r_stable,   n_stable;
    logic          r_cand,     n_cand;
    logic          r_ins_pend, n_ins_pend;
    logic          r_rem_pend, n_rem_pend;
    logic [TW-1:0] r_since,    n_since;
    logic [TW-1:0] r_last,     n_last;

    logic          ins;
    logic [TW-1:0] poll_age;
    logic [TW-1:0] cand_age;
    logic          changed;
    logic          taken;

    assign ins      = i_cfg.active_low ? ~i_item.pin_level : i_item.pin_level;
    assign poll_age = i_item.now_ms - r_last;
    assign cand_age = i_item.now_ms - r_since;

    always_comb begin
        n_known    = r_known;
        n_stable   = r_stable;
        n_cand     = r_cand;
        n_ins_pend = r_ins_pend;
        n_rem_pend = r_rem_pend;
        n_since    = r_since;
        n_last     = r_last;
        changed    = 1'b0;
        taken      = 1'b0;

        if (i_item.resync || !r_known) begin
            // capture current level, drop pending events
            n_known    = 1'b1;
            n_stable   = ins;
            n_cand     = ins;
            n_since    = i_item.now_ms;
            n_last     = i_item.now_ms;
            n_ins_pend = 1'b0;
            n_rem_pend = 1'b0;
        end else if ({16'd0, poll_age} >= {{TW{1'b0}}, i_cfg.poll_interval_ms}) begin
            n_last = i_item.now_ms;
            if (ins == r_stable || ins != r_cand) begin
                // restart candidate timer
                n_cand  = ins;
                n_since = i_item.now_ms;
            end else if ({16'd0, cand_age} >= {{TW{1'b0}}, i_cfg.debounce_ms}) begin
                n_ins_pend = ins;
                n_rem_pend = ~ins;
                n_stable   = ins;
                changed    = 1'b1;
            end
        end

        if (i_item.take_inserted && n_ins_pend) begin
            n_ins_pend = 1'b0;
            taken      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known    <= 1'b0;
            r_stable   <= 1'b0;
            r_cand     <= 1'b0;
            r_ins_pend <= 1'b0;
            r_rem_pend <= 1'b0;
            r_since    <= '0;
            r_last     <= '0;
        end else if (i_commit) begin
            r_known    <= n_known;
            r_stable   <= n_stable;
            r_cand     <= n_cand;
            r_ins_pend <= n_ins_pend;
            r_rem_pend <= n_rem_pend;
            r_since    <= n_since;
            r_last     <= n_last;
        end
    end

    assign o_result.changed              = changed;
    assign o_result.inserted_taken       = taken;
    assign o_result.removed_pending_out  = n_rem_pend;
    assign o_result.inserted_pending_out = n_ins_pend;
    assign o_result.card_present         = n_stable;

endmodule

>>> src/card_detect_debouncer.sv
// Channel   Direction  Handshake               Payload
// poll      in         i_in_valid / o_in_stall  i_in_data  (cdd_pkg::t_in)
// result    out        o_out_valid / i_out_stall o_out_data (cdd_pkg::t_out)
// config    in         i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One poll per cycle sustained while the output does not stall; each poll's result
// passes through the input register, then the result register, and is set by the
// combinational compare-and-update logic between them.
// Reset (synchronous, active low) empties both registers, clears the debounce
// state and loads the register defaults.
// An output stall holds the result register and, once the input register is
// full too, stalls the poll channel.
module card_detect_debouncer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cdd_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cdd_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [cdd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cdd_pkg::t_cfg cfg;
    cdd_pkg::t_in  r_in;
    logic          r_in_valid;
    cdd_pkg::t_out r_out;
    logic          r_out_valid;
    cdd_pkg::t_out result;
    logic          advance;
    logic          in_xfer;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    cdd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cdd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_commit (advance),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.removed_pending_out && o_out_data.inserted_pending_out))
        else $error("insert and removal both pending");

    a_change_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.changed) |->
            (o_out_data.removed_pending_out == !o_out_data.card_present))
        else $error("new stable level without matching event");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.inserted_taken) |-> !o_out_data.inserted_pending_out)
        else $error("insert event still pending after take");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("poll stalled with room in the pipeline");

endmodule
